FILE: rtl/core/gdo_pkg.sv
// ----------------------------------------------------------------------------
// gdo_pkg
// shared widths, codes, calendar helpers and the control store of the
// gregorian date day offset sequencer
// ----------------------------------------------------------------------------
package gdo_pkg;

  // field widths
  localparam int DAY_COUNT_BITS = 16;
  localparam int REQ_W          = 2;
  localparam int DAY_W          = 5;
  localparam int MONTH_W        = 4;
  localparam int YEAR_W         = 14;
  localparam int STATUS_W       = 2;
  localparam int YMOD_W         = 9;   // year modulo 400
  localparam int PC_W           = 5;

  // signed day accumulator: holds day + count and also a raw year
  localparam int ACC_W = (DAY_COUNT_BITS + 2 > YEAR_W + 1) ? DAY_COUNT_BITS + 2 : YEAR_W + 1;

  // request codes
  localparam logic [REQ_W-1:0] REQ_LOAD = 2'd0;
  localparam logic [REQ_W-1:0] REQ_ADD  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SUB  = 2'd2;

  // status codes
  localparam logic [STATUS_W-1:0] ST_OK       = 2'd0;
  localparam logic [STATUS_W-1:0] ST_BAD_DATE = 2'd1;
  localparam logic [STATUS_W-1:0] ST_RANGE    = 2'd2;

  // calendar constants
  localparam logic [YEAR_W-1:0]  YEAR_MIN   = 14'd1;
  localparam logic [YEAR_W-1:0]  YEAR_MAX   = 14'd9999;
  localparam logic [MONTH_W-1:0] MONTH_JAN  = 4'd1;
  localparam logic [MONTH_W-1:0] MONTH_FEB  = 4'd2;
  localparam logic [MONTH_W-1:0] MONTH_DEC  = 4'd12;
  localparam logic [YMOD_W-1:0]  YMOD_LAST  = 9'd399;
  localparam logic [YMOD_W-1:0]  YMOD_C100  = 9'd100;
  localparam logic [YMOD_W-1:0]  YMOD_C200  = 9'd200;
  localparam logic [YMOD_W-1:0]  YMOD_C300  = 9'd300;
  localparam logic signed [ACC_W-1:0] ACC_ZERO = '0;
  localparam logic signed [ACC_W-1:0] ACC_400  = ACC_W'(400);

  // reset date 1 jan 2000
  localparam logic [DAY_W-1:0]   RST_DAY   = 5'd1;
  localparam logic [MONTH_W-1:0] RST_MONTH = 4'd1;
  localparam logic [YEAR_W-1:0]  RST_YEAR  = 14'd2000;
  localparam logic [YMOD_W-1:0]  RST_YMOD  = 9'd0;

  // datapath operations
  typedef enum logic [3:0] {
    U_NOP,
    U_LATCH,
    U_LOAD_INIT,
    U_MOD400,
    U_LOAD_CHK,
    U_BAD_DATE,
    U_COMMIT,
    U_ADD_INIT,
    U_FWD,
    U_RANGE,
    U_SUB_INIT,
    U_BWD,
    U_EMIT
  } uop_t;

  // branch conditions
  typedef enum logic [3:0] {
    C_NEVER,
    C_ALWAYS,
    C_BEAT,
    C_REQ_ADD,
    C_REQ_SUB,
    C_REQ_LOAD,
    C_OUT_FREE,
    C_ACC_LT400,
    C_LOAD_BAD,
    C_FWD_EXIT,
    C_FITS_CUR,
    C_BWD_EXIT,
    C_ACC_POS
  } cond_t;

  // when the operation of a word runs
  typedef enum logic [1:0] {
    X_NOT_TAKEN,
    X_TAKEN,
    X_ALWAYS
  } exec_t;

  // fall-through sequencing
  typedef enum logic {
    S_NEXT,
    S_STAY
  } seq_t;

  typedef struct packed {
    uop_t              uop;
    cond_t             cond;
    exec_t             exec_mode;
    seq_t              seq;
    logic [PC_W-1:0]   target;
  } ucw_t;

  // control store addresses
  localparam logic [PC_W-1:0] A_IDLE    = 5'd0;
  localparam logic [PC_W-1:0] A_DISP_A  = 5'd1;
  localparam logic [PC_W-1:0] A_DISP_S  = 5'd2;
  localparam logic [PC_W-1:0] A_DISP_L  = 5'd3;
  localparam logic [PC_W-1:0] A_EMIT    = 5'd4;
  localparam logic [PC_W-1:0] A_LMOD    = 5'd5;
  localparam logic [PC_W-1:0] A_LCHK    = 5'd6;
  localparam logic [PC_W-1:0] A_LVAL    = 5'd7;
  localparam logic [PC_W-1:0] A_COMMIT  = 5'd8;
  localparam logic [PC_W-1:0] A_AINIT   = 5'd9;
  localparam logic [PC_W-1:0] A_FWD     = 5'd10;
  localparam logic [PC_W-1:0] A_FEXIT   = 5'd11;
  localparam logic [PC_W-1:0] A_RANGE_F = 5'd12;
  localparam logic [PC_W-1:0] A_SINIT   = 5'd13;
  localparam logic [PC_W-1:0] A_BWD     = 5'd14;
  localparam logic [PC_W-1:0] A_BEXIT   = 5'd15;
  localparam logic [PC_W-1:0] A_RANGE_B = 5'd16;
  localparam logic [PC_W-1:0] A_LAST    = A_RANGE_B;

  // leap rule on year mod 400: multiple of 4, but not of 100 unless of 400
  function automatic logic is_leap(input logic [YMOD_W-1:0] ymod);
    is_leap = (ymod[1:0] == 2'd0) && (ymod != YMOD_C100) && (ymod != YMOD_C200) &&
              (ymod != YMOD_C300);
  endfunction

  function automatic logic [DAY_W-1:0] month_len(input logic [MONTH_W-1:0] m,
                                                 input logic leap);
    case (m) inside
      MONTH_FEB:                  month_len = leap ? 5'd29 : 5'd28;
      4'd4, 4'd6, 4'd9, 4'd11:    month_len = 5'd30;
      default:                    month_len = 5'd31;
    endcase
  endfunction

  // control store
  function automatic ucw_t ucode(input logic [PC_W-1:0] pc);
    ucw_t w;
    w = '{uop: U_NOP, cond: C_ALWAYS, exec_mode: X_ALWAYS, seq: S_NEXT, target: A_IDLE};
    unique case (pc)
      // wait for a beat, capture it
      A_IDLE:    w = '{U_LATCH,     C_BEAT,      X_TAKEN,     S_STAY, A_DISP_A};
      // dispatch on request type
      A_DISP_A:  w = '{U_NOP,       C_REQ_ADD,   X_ALWAYS,    S_NEXT, A_AINIT};
      A_DISP_S:  w = '{U_NOP,       C_REQ_SUB,   X_ALWAYS,    S_NEXT, A_SINIT};
      A_DISP_L:  w = '{U_LOAD_INIT, C_REQ_LOAD,  X_TAKEN,     S_NEXT, A_LMOD};
      // hand the result over once the output register is free
      A_EMIT:    w = '{U_EMIT,      C_OUT_FREE,  X_TAKEN,     S_STAY, A_IDLE};
      // load: reduce the year mod 400, then check the date
      A_LMOD:    w = '{U_MOD400,    C_ACC_LT400, X_NOT_TAKEN, S_STAY, A_LCHK};
      A_LCHK:    w = '{U_LOAD_CHK,  C_NEVER,     X_ALWAYS,    S_NEXT, A_LVAL};
      A_LVAL:    w = '{U_BAD_DATE,  C_LOAD_BAD,  X_TAKEN,     S_NEXT, A_EMIT};
      A_COMMIT:  w = '{U_COMMIT,    C_ALWAYS,    X_ALWAYS,    S_NEXT, A_EMIT};
      // add: walk forward one month per step
      A_AINIT:   w = '{U_ADD_INIT,  C_NEVER,     X_ALWAYS,    S_NEXT, A_FWD};
      A_FWD:     w = '{U_FWD,       C_FWD_EXIT,  X_NOT_TAKEN, S_STAY, A_FEXIT};
      A_FEXIT:   w = '{U_NOP,       C_FITS_CUR,  X_ALWAYS,    S_NEXT, A_COMMIT};
      A_RANGE_F: w = '{U_RANGE,     C_ALWAYS,    X_ALWAYS,    S_NEXT, A_EMIT};
      // subtract: walk backward one month per step
      A_SINIT:   w = '{U_SUB_INIT,  C_NEVER,     X_ALWAYS,    S_NEXT, A_BWD};
      A_BWD:     w = '{U_BWD,       C_BWD_EXIT,  X_NOT_TAKEN, S_STAY, A_BEXIT};
      A_BEXIT:   w = '{U_NOP,       C_ACC_POS,   X_ALWAYS,    S_NEXT, A_COMMIT};
      A_RANGE_B: w = '{U_RANGE,     C_ALWAYS,    X_ALWAYS,    S_NEXT, A_EMIT};
      default:   w = '{U_NOP,       C_ALWAYS,    X_ALWAYS,    S_NEXT, A_IDLE};
    endcase
    ucode = w;
  endfunction

endpackage

FILE: rtl/core/gdo_req_if.sv
// ----------------------------------------------------------------------------
// gdo_req_if
// request channel: valid/ready with load, add and subtract payload
// ----------------------------------------------------------------------------
interface gdo_req_if;
  import gdo_pkg::*;

  logic                      valid;
  logic                      ready;
  logic [REQ_W-1:0]          req_type;
  logic [DAY_COUNT_BITS-1:0] day_count;
  logic [DAY_W-1:0]          load_day;
  logic [MONTH_W-1:0]        load_month;
  logic [YEAR_W-1:0]         load_year;

  modport source (
    output valid, req_type, day_count, load_day, load_month, load_year,
    input  ready
  );

  modport sink (
    input  valid, req_type, day_count, load_day, load_month, load_year,
    output ready
  );

endinterface

FILE: rtl/core/gdo_rsp_if.sv
// ----------------------------------------------------------------------------
// gdo_rsp_if
// response channel: valid/ready with the held date and a status
// ----------------------------------------------------------------------------
interface gdo_rsp_if;
  import gdo_pkg::*;

  logic                valid;
  logic                ready;
  logic [DAY_W-1:0]    cur_day;
  logic [MONTH_W-1:0]  cur_month;
  logic [YEAR_W-1:0]   cur_year;
  logic [STATUS_W-1:0] status;

  modport source (
    output valid, cur_day, cur_month, cur_year, status,
    input  ready
  );

  modport sink (
    input  valid, cur_day, cur_month, cur_year, status,
    output ready
  );

endinterface

FILE: rtl/core/gregorian_date_day_offset_top.sv
// ----------------------------------------------------------------------------
// gregorian_date_day_offset_top
// add and subtract walk month by month from the held date; load reduces the
// year mod 400 by repeated subtraction of 400, then checks the date
// up to about 2160 months are crossed for the largest day count: the month
// walk retires one month per cycle in a single add/compare step of the
// sequencer datapath; the next beat is taken after the response is registered
// synchronous reset: date 1 jan 2000, sequencer idle, no response pending
// ----------------------------------------------------------------------------
module gregorian_date_day_offset_top (
  input  logic         clk,
  input  logic         rst,
  gdo_req_if.sink      req,
  gdo_rsp_if.source    rsp
);
  import gdo_pkg::*;

  // sequencer
  logic [PC_W-1:0]           pc;
  logic [PC_W-1:0]           pc_next;
  ucw_t                      uw;
  logic                      taken;
  logic                      op_en;

  // captured request beat
  logic [REQ_W-1:0]          rq_type;
  logic [DAY_COUNT_BITS-1:0] rq_cnt;
  logic [DAY_W-1:0]          rq_day;
  logic [MONTH_W-1:0]        rq_mon;
  logic [YEAR_W-1:0]         rq_year;

  // working date: signed day accumulator, month, year, year mod 400
  logic signed [ACC_W-1:0]   acc;
  logic [MONTH_W-1:0]        mon;
  logic [YEAR_W-1:0]         yr;
  logic [YMOD_W-1:0]         ymod;
  logic [STATUS_W-1:0]       stat;

  // held date
  logic [DAY_W-1:0]          day_reg;
  logic [MONTH_W-1:0]        month_reg;
  logic [YEAR_W-1:0]         year_reg;
  logic [YMOD_W-1:0]         ymod_reg;

  // response register
  logic                      out_valid;
  logic [DAY_W-1:0]          out_day;
  logic [MONTH_W-1:0]        out_month;
  logic [YEAR_W-1:0]         out_year;
  logic [STATUS_W-1:0]       out_status;

  // month arithmetic
  logic [DAY_W-1:0]          len_cur;
  logic [DAY_W-1:0]          len_prev;
  logic signed [ACC_W-1:0]   len_cur_s;
  logic signed [ACC_W-1:0]   len_prev_s;
  logic [MONTH_W-1:0]        prev_mon;
  logic [YMOD_W-1:0]         prev_ymod;
  logic [YMOD_W-1:0]         next_ymod;
  logic                      fits_cur;
  logic                      acc_pos;
  logic                      load_bad;
  logic                      out_free;

  assign uw = ucode(pc);

  // ---------------------------------------------------------------------
  // month lengths of the current and of the preceding month
  // ---------------------------------------------------------------------
  always_comb begin
    prev_mon   = (mon == MONTH_JAN) ? MONTH_DEC : mon - MONTH_W'(1);
    prev_ymod  = ymod;
    if (mon == MONTH_JAN) begin
      // stepping back into december of the previous year
      prev_ymod = (ymod == '0) ? YMOD_LAST : ymod - YMOD_W'(1);
    end
    next_ymod  = (ymod == YMOD_LAST) ? '0 : ymod + YMOD_W'(1);
    len_cur    = month_len(mon, is_leap(ymod));
    len_prev   = month_len(prev_mon, is_leap(prev_ymod));
    len_cur_s  = ACC_W'(len_cur);
    len_prev_s = ACC_W'(len_prev);
  end

  assign fits_cur = (acc <= len_cur_s);
  assign acc_pos  = (acc > ACC_ZERO);
  assign out_free = !out_valid || rsp.ready;

  // a loaded date is checked after acc has taken the day of the request
  assign load_bad = (mon == '0) || (mon > MONTH_DEC) || (yr < YEAR_MIN) ||
                    (yr > YEAR_MAX) || !acc_pos || !fits_cur;

  // ---------------------------------------------------------------------
  // branch condition and operation enable
  // ---------------------------------------------------------------------
  always_comb begin
    unique case (uw.cond)
      C_NEVER:     taken = 1'b0;
      C_ALWAYS:    taken = 1'b1;
      C_BEAT:      taken = req.valid;
      C_REQ_ADD:   taken = (rq_type == REQ_ADD);
      C_REQ_SUB:   taken = (rq_type == REQ_SUB);
      C_REQ_LOAD:  taken = (rq_type == REQ_LOAD);
      C_OUT_FREE:  taken = out_free;
      C_ACC_LT400: taken = (acc < ACC_400);
      C_LOAD_BAD:  taken = load_bad;
      // forward walk stops when the day fits or the last december is reached
      C_FWD_EXIT:  taken = fits_cur || (mon == MONTH_DEC && yr == YEAR_MAX);
      C_FITS_CUR:  taken = fits_cur;
      // backward walk stops when the day is positive or at january of year 1
      C_BWD_EXIT:  taken = acc_pos || (mon == MONTH_JAN && yr == YEAR_MIN);
      C_ACC_POS:   taken = acc_pos;
      default:     taken = 1'b0;
    endcase
  end

  always_comb begin
    unique case (uw.exec_mode)
      X_NOT_TAKEN: op_en = !taken;
      X_TAKEN:     op_en = taken;
      X_ALWAYS:    op_en = 1'b1;
      default:     op_en = 1'b0;
    endcase
  end

  always_comb begin
    if (taken) begin
      pc_next = uw.target;
    end else if (uw.seq == S_STAY) begin
      pc_next = pc;
    end else begin
      pc_next = pc + PC_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pc <= A_IDLE;
    end else begin
      pc <= pc_next;
    end
  end

  // ---------------------------------------------------------------------
  // working datapath, no reset needed
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (op_en) begin
      unique case (uw.uop)
        U_LATCH: begin
          rq_type <= req.req_type;
          rq_cnt  <= req.day_count;
          rq_day  <= req.load_day;
          rq_mon  <= req.load_month;
          rq_year <= req.load_year;
          stat    <= ST_OK;
        end
        U_LOAD_INIT: begin
          acc <= ACC_W'(rq_year);
          mon <= rq_mon;
        end
        U_MOD400: begin
          acc <= acc - ACC_400;
        end
        U_LOAD_CHK: begin
          ymod <= acc[YMOD_W-1:0];
          yr   <= rq_year;
          acc  <= ACC_W'(rq_day);
        end
        U_BAD_DATE: begin
          stat <= ST_BAD_DATE;
        end
        U_ADD_INIT: begin
          acc  <= ACC_W'(day_reg) + ACC_W'(rq_cnt);
          mon  <= month_reg;
          yr   <= year_reg;
          ymod <= ymod_reg;
        end
        U_SUB_INIT: begin
          acc  <= ACC_W'(day_reg) - ACC_W'(rq_cnt);
          mon  <= month_reg;
          yr   <= year_reg;
          ymod <= ymod_reg;
        end
        U_FWD: begin
          // leave the current month: drop its length, carry into the year
          acc <= acc - len_cur_s;
          if (mon == MONTH_DEC) begin
            mon  <= MONTH_JAN;
            yr   <= yr + YEAR_W'(1);
            ymod <= next_ymod;
          end else begin
            mon <= mon + MONTH_W'(1);
          end
        end
        U_BWD: begin
          // enter the previous month: add its length, borrow from the year
          acc <= acc + len_prev_s;
          mon <= prev_mon;
          if (mon == MONTH_JAN) begin
            yr   <= yr - YEAR_W'(1);
            ymod <= prev_ymod;
          end
        end
        U_RANGE: begin
          stat <= ST_RANGE;
        end
        default: begin
        end
      endcase
    end
  end

  // ---------------------------------------------------------------------
  // held date, updated only by a successful request
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      day_reg   <= RST_DAY;
      month_reg <= RST_MONTH;
      year_reg  <= RST_YEAR;
      ymod_reg  <= RST_YMOD;
    end else if (op_en && uw.uop == U_COMMIT) begin
      day_reg   <= acc[DAY_W-1:0];
      month_reg <= mon;
      year_reg  <= yr;
      ymod_reg  <= ymod;
    end
  end

  // ---------------------------------------------------------------------
  // response register: one beat per request
  // ---------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (op_en && uw.uop == U_EMIT) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (op_en && uw.uop == U_EMIT) begin
      out_day    <= day_reg;
      out_month  <= month_reg;
      out_year   <= year_reg;
      out_status <= stat;
    end
  end

  // request side is open only while the sequencer waits at idle, out of reset
  assign req.ready     = (pc == A_IDLE) && !rst;
  assign rsp.valid     = out_valid;
  assign rsp.cur_day   = out_day;
  assign rsp.cur_month = out_month;
  assign rsp.cur_year  = out_year;
  assign rsp.status    = out_status;

  // ---------------------------------------------------------------------
  // checks
  // ---------------------------------------------------------------------
  a_beat_dispatch: assert property (@(posedge clk) disable iff (rst)
    req.valid && req.ready |=> pc == A_DISP_A)
    else $error("request beat did not start dispatch");

  a_emit_waits: assert property (@(posedge clk) disable iff (rst)
    pc == A_EMIT && out_valid && !rsp.ready |=> pc == A_EMIT && out_valid)
    else $error("response overwritten while still pending");

  a_commit_ok: assert property (@(posedge clk) disable iff (rst)
    pc == A_COMMIT |-> stat == ST_OK)
    else $error("date committed with an error status");

  a_held_valid: assert property (@(posedge clk) disable iff (rst)
    month_reg >= MONTH_JAN && month_reg <= MONTH_DEC && day_reg != '0 &&
    year_reg >= YEAR_MIN && year_reg <= YEAR_MAX)
    else $error("held date out of range");

  a_pc_bound: assert property (@(posedge clk) disable iff (rst)
    pc <= A_LAST)
    else $error("sequencer left the control store");

endmodule
